// File: hw/rtl/emat_pkg.sv
// package for the adaptive motion threshold block
// command struct between controller and datapath, saturating update functions
// no dependencies
`timescale 1ns / 1ps

package emat_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned FactorW = 16;
	localparam int unsigned WeightW = 17;
	localparam int unsigned ProdW   = 52;
	localparam int unsigned AddrW   = 4;
	localparam int unsigned ResultW = 4 * DataW;

	localparam logic [WeightW-1:0] AlphaOne = WeightW'(65536);

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] RegBase   = 2'd0;
	localparam logic [1:0] RegFactor = 2'd1;
	localparam logic [1:0] RegWeight = 2'd2;

	localparam logic [DataW-1:0]   BaseReset   = '0;
	localparam logic [FactorW-1:0] FactorReset = FactorW'(512);
	localparam logic [WeightW-1:0] WeightReset = WeightW'(6554);

	// one bit per controller step, at most one set per cycle
	typedef struct packed {
		logic load_sad;
		logic seed;
		logic calc_delta;
		logic calc_prior;
		logic upd_mean;
		logic upd_spread;
		logic scale_spread;
		logic load_out;
	} cmd_t;

	// base + floor(factor * spread / 2^8), saturated at 32 bits
	function automatic logic [DataW-1:0] thr_sat(input logic [DataW-1:0] base,
			input logic signed [ProdW-1:0] p);
		logic [40:0] sum;
		sum = {9'd0, base} + {1'b0, p[47:8]};
		return (sum[40:32] != '0) ? '1 : sum[DataW-1:0];
	endfunction

	// cur + floor(p / 2^16), clamped to the unsigned 32-bit range
	function automatic logic [DataW-1:0] ema_sat(input logic [DataW-1:0] cur,
			input logic signed [ProdW-1:0] p);
		logic signed [36:0] sum;
		sum = $signed({5'd0, cur}) + $signed({p[ProdW-1], p[ProdW-1:16]});
		if (sum[36])
			return '0;
		else if (sum[35:32] != '0)
			return '1;
		else
			return sum[DataW-1:0];
	endfunction

endpackage

// File: hw/rtl/ema_adaptive_motion_threshold.sv
// adaptive motion threshold: the first request after reset only seeds the mean and prior
// threshold (seeding); later requests run the full update, then the result is registered
// one request in flight; the next request is taken once the controller is back in idle:
// a later request runs six controller steps, four of them on the one shared multiplier;
// seeding runs only the seed and final steps; idle comes later if the result is not taken
// arst_n clears the seeded flag, the controller and output valid, and loads register defaults
// top level: apb register file, controller and datapath; depends on emat_pkg
`timescale 1ns / 1ps

module ema_adaptive_motion_threshold (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [emat_pkg::AddrW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// score requests
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // sad_score
	// threshold results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// prior_threshold, new_threshold, mean_level, spread_level
	output logic [emat_pkg::ResultW-1:0] m_tdata
);
	import emat_pkg::*;

	logic [DataW-1:0]   base_q;
	logic [FactorW-1:0] factor_q;
	logic [WeightW-1:0] weight_q;
	logic               cfg_wr;
	cmd_t               cmd;

	// apb: no wait states, write lands on the access cycle
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BaseReset;
			factor_q <= FactorReset;
			weight_q <= WeightReset;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				RegBase:   base_q   <= pwdata;
				RegFactor: factor_q <= pwdata[FactorW-1:0];
				RegWeight: weight_q <= pwdata[WeightW-1:0];
				default: ;  // unmapped, write dropped
			endcase
		end
	end

	// read back, unmapped addresses read zero
	always_comb begin
		unique case (paddr[3:2])
			RegBase:   prdata = base_q;
			RegFactor: prdata = {16'd0, factor_q};
			RegWeight: prdata = {15'd0, weight_q};
			default:   prdata = '0;
		endcase
	end

	// controller: one step per state, holds the result until taken
	emat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// datapath: mean/spread update and threshold scaling
	emat_dp u_dp (
		.clk    (clk),
		.cmd    (cmd),
		.sad_in (s_tdata),
		.base   (base_q),
		.factor (factor_q),
		.weight (weight_q),
		.result (m_tdata)
	);

endmodule

// File: hw/rtl/emat_ctrl.sv
// controller state machine for the adaptive motion threshold block
// sequences the shared multiplier steps, owns the seeded flag and output valid
// depends on emat_pkg
`timescale 1ns / 1ps

module emat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output emat_pkg::cmd_t cmd
);
	import emat_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SEED   = 8'b0000_0010,
		ST_PRIOR  = 8'b0000_0100,
		ST_MEAN   = 8'b0000_1000,
		ST_SPREAD = 8'b0001_0000,
		ST_UPDS   = 8'b0010_0000,
		ST_SCALE  = 8'b0100_0000,
		ST_FINAL  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   seeded_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_sad = accept;
				if (accept)
					state_d = seeded_q ? ST_PRIOR : ST_SEED;
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d  = ST_FINAL;
			end
			ST_PRIOR: begin
				cmd.calc_delta = 1'b1;
				state_d        = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.calc_prior = 1'b1;
				state_d        = ST_SPREAD;
			end
			ST_SPREAD: begin
				cmd.upd_mean = 1'b1;
				state_d      = ST_UPDS;
			end
			ST_UPDS: begin
				cmd.upd_spread = 1'b1;
				state_d        = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale_spread = 1'b1;
				state_d          = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.load_out = out_free;
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.seed)
				seeded_q <= 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/emat_dp.sv
// datapath for the adaptive motion threshold block
// shared 18x34 signed multiplier, running mean and spread, output register
// depends on emat_pkg
`timescale 1ns / 1ps

module emat_dp (
	input  logic                          clk,
	input  emat_pkg::cmd_t                cmd,
	input  logic [emat_pkg::DataW-1:0]   sad_in,
	input  logic [emat_pkg::DataW-1:0]   base,
	input  logic [emat_pkg::FactorW-1:0] factor,
	input  logic [emat_pkg::WeightW-1:0] weight,
	output logic [emat_pkg::ResultW-1:0] result
);
	import emat_pkg::*;

	logic [DataW-1:0]          sad_q;
	logic [DataW-1:0]          mean_q;
	logic [DataW-1:0]          spread_q;
	logic [DataW-1:0]          prior_q;
	logic signed [DataW:0]     delta_q;
	logic signed [DataW+1:0]   d2_q;
	logic signed [ProdW-1:0]   prod_q;
	logic [ResultW-1:0]        result_q;

	logic [WeightW-1:0]        alpha;
	logic [DataW:0]            delta_mag;
	logic [WeightW-1:0]        mul_a;
	logic signed [DataW+1:0]   mul_b;
	logic signed [ProdW-1:0]   prod_d;

	// weights above one act as one
	assign alpha     = weight[WeightW-1] ? AlphaOne : weight;
	assign delta_mag = delta_q[DataW] ? (DataW+1)'(0) - delta_q : delta_q;

	always_comb begin
		priority if (cmd.calc_prior) begin
			mul_a = alpha;
			mul_b = {delta_q[DataW], delta_q};
		end else if (cmd.upd_mean) begin
			mul_a = alpha;
			mul_b = d2_q;
		end else begin
			mul_a = {1'b0, factor};
			mul_b = $signed({2'b00, spread_q});
		end
	end

	assign prod_d = $signed({1'b0, mul_a}) * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.load_sad)
			sad_q <= sad_in;
		if (cmd.seed) begin
			mean_q   <= sad_q;
			spread_q <= '0;
			prior_q  <= base;
			prod_q   <= '0;
		end
		if (cmd.calc_delta)
			delta_q <= $signed({1'b0, sad_q}) - $signed({1'b0, mean_q});
		if (cmd.calc_delta || cmd.calc_prior || cmd.upd_mean || cmd.scale_spread)
			prod_q <= prod_d;
		if (cmd.calc_prior) begin
			prior_q <= thr_sat(base, prod_q);
			d2_q    <= $signed({1'b0, delta_mag}) - $signed({2'b00, spread_q});
		end
		if (cmd.upd_mean)
			mean_q <= ema_sat(mean_q, prod_q);
		if (cmd.upd_spread)
			spread_q <= ema_sat(spread_q, prod_q);
		if (cmd.load_out)
			result_q <= {spread_q, mean_q, thr_sat(base, prod_q), prior_q};
	end

	assign result = result_q;

endmodule

// File: hw/rtl/emat_checker.sv
// port-level checker for the adaptive motion threshold block
// bound to ema_adaptive_motion_threshold; depends on emat_pkg
`timescale 1ns / 1ps

module emat_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [emat_pkg::ResultW-1:0] m_tdata
);
	import emat_pkg::*;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight: ready stays low after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("request taken while busy");

	// a new result only comes out of a busy step
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a request in flight");

endmodule

bind ema_adaptive_motion_threshold emat_checker u_emat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
